// ----- rtl/core/iep_pkg.sv -----
// Shared types and constants for the ICMP echo ping engine.
// No dependencies; the top-level, front, queue, back and checker files import this package.
package iep_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_TARGET   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDENT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 3'd4;

  localparam logic [15:0] RST_IDENT    = 16'h5542;
  localparam logic [7:0]  RST_COUNT    = 8'd4;
  localparam logic [15:0] RST_INTERVAL = 16'd1000;
  localparam logic [15:0] RST_TIMEOUT  = 16'd5000;

  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_TICK  = 2'd1;
  localparam logic [1:0] ACT_BYTE  = 2'd2;
  localparam logic [1:0] ACT_ABORT = 2'd3;

  localparam logic [1:0] EV_REQUEST = 2'd0;
  localparam logic [1:0] EV_REPLY   = 2'd1;
  localparam logic [1:0] EV_TIMEOUT = 2'd2;
  localparam logic [1:0] EV_ABORT   = 2'd3;

  localparam logic [7:0] ICMP_ECHO_REQUEST = 8'd8;
  localparam logic [7:0] ICMP_PROTOCOL_NUM = 8'd1;
  localparam logic [5:0] MIN_HEADER_BYTES  = 6'd20;
  localparam logic [6:0] ICMP_HEADER_BYTES = 7'd8;
  localparam logic [6:0] RX_COUNT_MAX      = 7'd127;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] seq;
    logic [15:0] ident;
  } cmd_t;

endpackage

// ----- rtl/core/iep_ifs.sv -----
// Valid/ready channel interfaces for the ICMP echo ping engine.
// No dependencies.
interface iep_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] packet_byte;
  logic       packet_last;

  modport source (output valid, action, packet_byte, packet_last, input ready);
  modport sink (input valid, action, packet_byte, packet_last, output ready);
endinterface

interface iep_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_res;
  logic [7:0]  tx_byte;
  logic [15:0] reply_seq;
  logic        last;

  modport source (output valid, event_res, tx_byte, reply_seq, last, input ready);
  modport sink (input valid, event_res, tx_byte, reply_seq, last, output ready);
endinterface

// ----- rtl/core/icmp_echo_ping_engine_unit.sv -----
// ICMP echo ping engine, top level: front part, command queue and back part.
// Depends on iep_pkg, iep_ifs, iep_front, iep_queue and iep_back.
//
// The engine takes one item per clock cycle (start, tick, received packet
// byte or abort) as long as its four-entry command queue has room. Each item
// is settled in the front part in the cycle it is accepted; an item that
// causes results leaves one command in the queue. The back part turns a
// command into result items at one per cycle, output stalls apart, through a
// registered output: an echo request becomes eight byte results, a reply,
// timeout or abort one. Packet bytes therefore stream at full rate, and a
// sending tick holds the output for eight bytes while the front keeps accepting.
module icmp_echo_ping_engine_unit import iep_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  iep_item_if.sink              item,
  iep_result_if.source          result,
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic push;
  cmd_t push_cmd;
  logic full;
  logic pop;
  cmd_t head;
  logic empty;

  iep_front u_front (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (full)
  );

  iep_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .head     (head),
    .empty    (empty)
  );

  iep_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

endmodule

// ----- rtl/core/iep_front.sv -----
// Front part: configuration registers, session timing and receive parser.
// Depends on iep_pkg and iep_item_if; pushes result commands into the queue.
module iep_front import iep_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  iep_item_if.sink              item,
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic                  push,
  output cmd_t                  push_cmd,
  input  logic                  full
);

  logic [31:0] target_address;
  logic [15:0] echo_identifier;
  logic [7:0]  request_count;
  logic [15:0] interval_ticks;
  logic [15:0] timeout_ticks;

  logic        session_active, session_active_next;
  logic [7:0]  sent_sequence, sent_sequence_next;
  logic [15:0] elapsed_ticks, elapsed_ticks_next;
  logic [23:0] send_tick, send_tick_next;
  logic [6:0]  rx_byte_count, rx_byte_count_next;
  logic [5:0]  rx_header_bytes, rx_header_bytes_next;
  logic        rx_match, rx_match_next;
  logic [15:0] rx_identifier, rx_identifier_next;
  logic [15:0] rx_sequence, rx_sequence_next;

  logic        accept;
  logic        timed_out, send_due;
  logic [7:0]  seq_new;
  logic [24:0] send_sum;
  logic [23:0] send_sat;
  logic        in_range;
  logic [5:0]  hl_new, hl;
  logic [6:0]  hl_ext;
  logic [2:0]  off;
  logic        in_icmp;
  logic [7:0]  want;
  logic        b_match;
  logic [15:0] b_ident, b_seq;
  logic [6:0]  b_count;
  logic        reply_ok;

  assign item.ready = !full;
  assign accept = item.valid && item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_address  <= '0;
      echo_identifier <= RST_IDENT;
      request_count   <= RST_COUNT;
      interval_ticks  <= RST_INTERVAL;
      timeout_ticks   <= RST_TIMEOUT;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        CFG_TARGET:   target_address  <= cfg_wdata;
        CFG_IDENT:    echo_identifier <= cfg_wdata[15:0];
        CFG_COUNT:    request_count   <= cfg_wdata[7:0];
        CFG_INTERVAL: interval_ticks  <= cfg_wdata[15:0];
        CFG_TIMEOUT:  timeout_ticks   <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // tick checks
  always_comb begin
    timed_out = elapsed_ticks >= timeout_ticks;
    send_due  = (sent_sequence < request_count) && ({8'd0, elapsed_ticks} >= send_tick);
    seq_new   = sent_sequence + 8'd1;
    send_sum  = {1'b0, send_tick} + {9'd0, interval_ticks};
    send_sat  = send_sum[24] ? 24'hFF_FFFF : send_sum[23:0];
  end

  // receive parser
  always_comb begin
    in_range = rx_byte_count != RX_COUNT_MAX;
    hl_new   = {item.packet_byte[3:0], 2'b00};
    hl       = (in_range && rx_byte_count == 7'd0) ? hl_new : rx_header_bytes;
    hl_ext   = {1'b0, hl};
    off      = 3'(rx_byte_count - hl_ext);
    in_icmp  = (rx_byte_count >= hl_ext) && (rx_byte_count < hl_ext + ICMP_HEADER_BYTES)
               && (rx_byte_count >= {1'b0, MIN_HEADER_BYTES});
    case (rx_byte_count[1:0])
      2'd0:    want = target_address[31:24];
      2'd1:    want = target_address[23:16];
      2'd2:    want = target_address[15:8];
      default: want = target_address[7:0];
    endcase
    b_match = rx_match;
    b_ident = rx_identifier;
    b_seq   = rx_sequence;
    b_count = rx_byte_count;
    if (in_range) begin
      if (rx_byte_count == 7'd0) begin
        if (hl_new < MIN_HEADER_BYTES) b_match = 1'b0;
      end else if (rx_byte_count == 7'd9) begin
        if (item.packet_byte != ICMP_PROTOCOL_NUM) b_match = 1'b0;
      end else if (rx_byte_count >= 7'd12 && rx_byte_count <= 7'd15) begin
        if (item.packet_byte != want) b_match = 1'b0;
      end
      if (in_icmp) begin
        case (off)
          3'd0, 3'd1: if (item.packet_byte != 8'd0) b_match = 1'b0;
          3'd4: b_ident[15:8] = item.packet_byte;
          3'd5: b_ident[7:0]  = item.packet_byte;
          3'd6: b_seq[15:8]   = item.packet_byte;
          3'd7: b_seq[7:0]    = item.packet_byte;
          default: ;
        endcase
      end
      b_count = rx_byte_count + 7'd1;
    end
    reply_ok = item.packet_last && session_active && b_match && (hl >= MIN_HEADER_BYTES)
               && (b_count >= hl_ext + ICMP_HEADER_BYTES) && (b_ident == echo_identifier)
               && (b_seq != 16'd0) && (b_seq <= {8'd0, sent_sequence});
  end

  always_comb begin
    session_active_next  = session_active;
    sent_sequence_next   = sent_sequence;
    elapsed_ticks_next   = elapsed_ticks;
    send_tick_next       = send_tick;
    rx_byte_count_next   = rx_byte_count;
    rx_header_bytes_next = rx_header_bytes;
    rx_match_next        = rx_match;
    rx_identifier_next   = rx_identifier;
    rx_sequence_next     = rx_sequence;
    push                 = 1'b0;
    push_cmd.kind        = EV_ABORT;
    push_cmd.seq         = '0;
    push_cmd.ident       = echo_identifier;
    if (accept) begin
      unique case (item.action)
        ACT_START: begin
          session_active_next  = 1'b1;
          sent_sequence_next   = '0;
          elapsed_ticks_next   = '0;
          send_tick_next       = '0;
          rx_byte_count_next   = '0;
          rx_header_bytes_next = '0;
          rx_match_next        = 1'b1;
          rx_identifier_next   = '0;
          rx_sequence_next     = '0;
        end
        ACT_TICK: begin
          if (session_active) begin
            if (timed_out) begin
              session_active_next = 1'b0;
              push                = 1'b1;
              push_cmd.kind       = EV_TIMEOUT;
            end else begin
              if (send_due) begin
                sent_sequence_next = seq_new;
                send_tick_next     = send_sat;
                push               = 1'b1;
                push_cmd.kind      = EV_REQUEST;
                push_cmd.seq       = {8'd0, seq_new};
              end
              if (elapsed_ticks != 16'hFFFF) elapsed_ticks_next = elapsed_ticks + 16'd1;
            end
          end
        end
        ACT_BYTE: begin
          if (item.packet_last) begin
            rx_byte_count_next   = '0;
            rx_header_bytes_next = '0;
            rx_match_next        = 1'b1;
            rx_identifier_next   = '0;
            rx_sequence_next     = '0;
          end else begin
            rx_byte_count_next   = b_count;
            rx_header_bytes_next = hl;
            rx_match_next        = b_match;
            rx_identifier_next   = b_ident;
            rx_sequence_next     = b_seq;
          end
          if (reply_ok) begin
            session_active_next = 1'b0;
            push                = 1'b1;
            push_cmd.kind       = EV_REPLY;
            push_cmd.seq        = b_seq;
          end
        end
        ACT_ABORT: begin
          if (session_active) begin
            session_active_next = 1'b0;
            push                = 1'b1;
            push_cmd.kind       = EV_ABORT;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      session_active  <= 1'b0;
      sent_sequence   <= '0;
      elapsed_ticks   <= '0;
      send_tick       <= '0;
      rx_byte_count   <= '0;
      rx_header_bytes <= '0;
      rx_match        <= 1'b1;
      rx_identifier   <= '0;
      rx_sequence     <= '0;
    end else begin
      session_active  <= session_active_next;
      sent_sequence   <= sent_sequence_next;
      elapsed_ticks   <= elapsed_ticks_next;
      send_tick       <= send_tick_next;
      rx_byte_count   <= rx_byte_count_next;
      rx_header_bytes <= rx_header_bytes_next;
      rx_match        <= rx_match_next;
      rx_identifier   <= rx_identifier_next;
      rx_sequence     <= rx_sequence_next;
    end
  end

endmodule

// ----- rtl/core/iep_queue.sv -----
// Short command queue between the front and back parts of the engine.
// Depends on iep_pkg for the command type and depth.
module iep_queue import iep_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t head,
  output logic empty
);

  cmd_t                entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign full  = count == (QUEUE_AW+1)'(QUEUE_DEPTH);
  assign empty = count == '0;
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) entries[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) wr_ptr <= wr_ptr + 1'b1;
      if (pop && !empty) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QUEUE_AW+1)'(push && !full) - (QUEUE_AW+1)'(pop && !empty);
    end
  end

endmodule

// ----- rtl/core/iep_back.sv -----
// Back part: expands queued commands into result items behind an output register.
// Depends on iep_pkg and iep_result_if; builds echo request bytes and checksum.
module iep_back import iep_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        head,
  input  logic        empty,
  output logic        pop,
  iep_result_if.source result
);

  logic        valid;
  logic [1:0]  event_res;
  logic [7:0]  tx_byte;
  logic [15:0] reply_seq;
  logic        last;
  logic [2:0]  idx;

  logic        load_ok;
  logic        emit;
  logic [17:0] sum1;
  logic [16:0] sum2;
  logic [15:0] sum3;
  logic [15:0] cksum;
  logic [7:0]  req_byte;

  assign result.valid     = valid;
  assign result.event_res = event_res;
  assign result.tx_byte   = tx_byte;
  assign result.reply_seq = reply_seq;
  assign result.last      = last;

  always_comb begin
    sum1  = 18'h0800 + {2'b00, head.ident} + {2'b00, head.seq};
    sum2  = {1'b0, sum1[15:0]} + {15'd0, sum1[17:16]};
    sum3  = sum2[15:0] + {15'd0, sum2[16]};
    cksum = ~sum3;
    case (idx)
      3'd0:    req_byte = ICMP_ECHO_REQUEST;
      3'd1:    req_byte = 8'd0;
      3'd2:    req_byte = cksum[15:8];
      3'd3:    req_byte = cksum[7:0];
      3'd4:    req_byte = head.ident[15:8];
      3'd5:    req_byte = head.ident[7:0];
      3'd6:    req_byte = head.seq[15:8];
      default: req_byte = head.seq[7:0];
    endcase
    load_ok = !valid || result.ready;
    emit    = load_ok && !empty;
    pop     = emit && (head.kind != EV_REQUEST || idx == 3'd7);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= '0;
    end else if (load_ok) begin
      valid <= !empty;
      if (emit) idx <= pop ? 3'd0 : idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      event_res <= head.kind;
      tx_byte   <= (head.kind == EV_REQUEST) ? req_byte : 8'd0;
      reply_seq <= (head.kind == EV_REPLY) ? head.seq : 16'd0;
      last      <= pop;
    end
  end

endmodule

// ----- rtl/core/iep_checker.sv -----
// Port-level checks for the ICMP echo ping engine, bound to the top level.
// Depends on iep_pkg for result codes.
module iep_checker import iep_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        item_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic [1:0]  event_res,
  input logic [7:0]  tx_byte,
  input logic [15:0] reply_seq,
  input logic        last
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  a_ready_after_reset: assert property (@(posedge clk) rst |=> item_ready)
    else $error("input not ready after reset");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && event_res != EV_REQUEST |-> last)
    else $error("single result item not marked last");

  a_field_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (event_res == EV_REQUEST || tx_byte == 8'd0)
               && (event_res == EV_REPLY || reply_seq == 16'd0))
    else $error("unused result field not zero");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(event_res) && $stable(tx_byte)
                             && $stable(last))
    else $error("stalled result changed");

endmodule

bind icmp_echo_ping_engine_unit iep_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .item_ready (item.ready),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .event_res  (result.event_res),
  .tx_byte    (result.tx_byte),
  .reply_seq  (result.reply_seq),
  .last       (result.last)
);
